// ===== sv/oaht_pkg.sv =====
// Shared types and constants for the open-addressing hash table.
`default_nettype none
package oaht_pkg;
	localparam int SizeW  = 11;
	localparam int CollW  = 48;
	localparam int HashW  = 64;
	localparam int StepShift = 16;
	localparam int CntW   = $clog2(HashW);
	localparam int MinSize = 13;
	localparam int RedW   = 16;
	localparam int CfgIdxW  = 1;
	localparam int CfgDataW = 11;
	localparam logic [CollW-1:0] CollMax = '1;
	localparam logic [CfgIdxW-1:0] CFG_PROBE_MODE = 1'd0;
	localparam logic [CfgIdxW-1:0] CFG_TABLE_SIZE = 1'd1;
	localparam logic [RedW-1:0] CustLin  = 16'd17;
	localparam logic [RedW-1:0] CustQuad = 16'd31;
	localparam logic [SizeW-1:0] CustQuadInc = 11'd62;

	typedef enum logic [1:0] {
		KIND_SEARCH = 2'd0,
		KIND_INSERT = 2'd1,
		KIND_ERASE  = 2'd2,
		KIND_OTHER  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_DUP  = 2'd2,
		ST_FULL = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		MARK_EMPTY = 2'd0,
		MARK_OCC   = 2'd1,
		MARK_DEL   = 2'd2
	} mark_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_DIV,
		F_RED,
		F_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		B_CLEAR,
		B_IDLE,
		B_RD,
		B_EV
	} back_state_t;

	typedef struct packed {
		kind_t            kind;
		logic [SizeW-1:0] m;
		logic [SizeW-1:0] home;
		logic [SizeW-1:0] d0;
		logic [SizeW-1:0] inc;
	} job_t;
endpackage
`default_nettype wire

// ===== sv/oaht_front.sv =====
// Front end: takes an item, derives home slot and probe increments.
`default_nettype none
module oaht_front #(
	parameter int TABLE_DEPTH = 1024,
	parameter int KEY_WIDTH   = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        take,
	input  wire logic [1:0]                  kind,
	input  wire logic [KEY_WIDTH-1:0]        key,
	input  wire logic [oaht_pkg::HashW-1:0]  key_hash,
	input  wire logic [VALUE_WIDTH-1:0]      value,
	input  wire logic                        probe_mode,
	input  wire logic [oaht_pkg::SizeW-1:0]  table_size,
	input  wire logic                        q_full,
	output logic                             busy,
	output logic                             push,
	output oaht_pkg::job_t                   job,
	output logic [KEY_WIDTH-1:0]             push_key,
	output logic [VALUE_WIDTH-1:0]           push_value
);
	import oaht_pkg::*;

	front_state_t state_q, state_d;
	kind_t               kind_q;
	logic [KEY_WIDTH-1:0]   key_q;
	logic [VALUE_WIDTH-1:0] value_q;
	logic                mode_q;
	logic [SizeW-1:0]    m_q, m_eff, r1_q, r2_q, r1_n, r2_n, mm1, step, acc2_q;
	logic [HashW-1:0]    sh_q, sh2_q;
	logic [CntW-1:0]     cnt_q;
	logic [RedW-1:0]     acc_q, m16;
	logic [SizeW:0]      t1, t2;
	logic                div_last, red_done;

	always_comb begin
		if (table_size < SizeW'(MinSize))
			m_eff = SizeW'(MinSize);
		else if (32'(table_size) > TABLE_DEPTH)
			m_eff = SizeW'(TABLE_DEPTH);
		else
			m_eff = table_size;
	end

	assign mm1 = m_q - 1'b1;
	assign t1  = {r1_q, sh_q[HashW-1]};
	assign t2  = {r2_q, sh2_q[HashW-1]};
	assign r1_n = (t1 >= {1'b0, m_q}) ? SizeW'(t1 - {1'b0, m_q}) : SizeW'(t1);
	assign r2_n = (t2 >= {1'b0, mm1}) ? SizeW'(t2 - {1'b0, mm1}) : SizeW'(t2);
	assign step = r2_n + 1'b1;
	assign m16  = RedW'(m_q);
	assign div_last = (cnt_q == CntW'(HashW - 1));
	assign red_done = (acc_q < m16) && (acc2_q < m_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= F_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		push    = 1'b0;
		unique case (state_q)
			F_IDLE: if (take) state_d = F_DIV;
			F_DIV:  if (div_last) state_d = F_RED;
			F_RED:  if (red_done) state_d = F_PUSH;
			F_PUSH: begin
				if (!q_full) begin
					push    = 1'b1;
					state_d = F_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			F_IDLE: begin
				if (take) begin
					kind_q  <= kind_t'(kind);
					key_q   <= key;
					value_q <= value;
					mode_q  <= probe_mode;
					m_q     <= m_eff;
					sh_q    <= key_hash;
					sh2_q   <= {StepShift'(0), key_hash[HashW-1:StepShift]};
					r1_q    <= '0;
					r2_q    <= '0;
					cnt_q   <= '0;
				end
			end
			F_DIV: begin
				r1_q  <= r1_n;
				r2_q  <= r2_n;
				sh_q  <= {sh_q[HashW-2:0], 1'b0};
				sh2_q <= {sh2_q[HashW-2:0], 1'b0};
				cnt_q <= cnt_q + 1'b1;
				if (div_last) begin
					acc_q  <= mode_q ? RedW'(step) * CustLin + CustQuad : RedW'(step);
					acc2_q <= mode_q ? CustQuadInc : '0;
				end
			end
			F_RED: begin
				if (acc_q >= m16) acc_q <= acc_q - m16;
				if (acc2_q >= m_q) acc2_q <= acc2_q - m_q;
			end
			F_PUSH: ;
		endcase
	end

	assign busy       = (state_q != F_IDLE);
	assign job.kind   = kind_q;
	assign job.m      = m_q;
	assign job.home   = r1_q;
	assign job.d0     = SizeW'(acc_q);
	assign job.inc    = acc2_q;
	assign push_key   = key_q;
	assign push_value = value_q;
endmodule
`default_nettype wire

// ===== sv/oaht_fifo.sv =====
// Two-entry queue between front end and probe engine.
`default_nettype none
module oaht_fifo #(
	parameter int KEY_WIDTH   = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push,
	input  wire oaht_pkg::job_t         push_job,
	input  wire logic [KEY_WIDTH-1:0]   push_key,
	input  wire logic [VALUE_WIDTH-1:0] push_value,
	input  wire logic                   pop,
	output logic                        full,
	output logic                        valid,
	output oaht_pkg::job_t              job,
	output logic [KEY_WIDTH-1:0]        key,
	output logic [VALUE_WIDTH-1:0]      value
);
	import oaht_pkg::*;

	job_t                   job_q   [2];
	logic [KEY_WIDTH-1:0]   key_q   [2];
	logic [VALUE_WIDTH-1:0] value_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop)  rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			job_q[wp_q]   <= push_job;
			key_q[wp_q]   <= push_key;
			value_q[wp_q] <= push_value;
		end
	end

	assign full  = (cnt_q == 2'd2);
	assign valid = (cnt_q != 2'd0);
	assign job   = job_q[rp_q];
	assign key   = key_q[rp_q];
	assign value = value_q[rp_q];

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> valid) else $error("queue underflow");
endmodule
`default_nettype wire

// ===== sv/oaht_back.sv =====
// Probe engine: slot memories, search/insert/erase sequencing, counters.
`default_nettype none
module oaht_back #(
	parameter int TABLE_DEPTH = 1024,
	parameter int KEY_WIDTH   = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         q_valid,
	input  wire oaht_pkg::job_t               q_job,
	input  wire logic [KEY_WIDTH-1:0]         q_key,
	input  wire logic [VALUE_WIDTH-1:0]       q_value,
	output logic                              q_pop,
	output logic                              clearing,
	output logic                              done,
	output logic [1:0]                        status,
	output logic [VALUE_WIDTH-1:0]            found_value,
	output logic [oaht_pkg::SizeW-1:0]        probe_count,
	output logic [oaht_pkg::CollW-1:0]        collision_total,
	output logic [oaht_pkg::SizeW-1:0]        item_count
);
	import oaht_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);

	mark_t                  mark_mem [TABLE_DEPTH];
	logic [KEY_WIDTH-1:0]   key_mem  [TABLE_DEPTH];
	logic [VALUE_WIDTH-1:0] val_mem  [TABLE_DEPTH];
	mark_t                  mark_rd_q;
	logic [KEY_WIDTH-1:0]   key_rd_q;
	logic [VALUE_WIDTH-1:0] val_rd_q;

	back_state_t state_q, state_d;
	job_t  job_q, job_d;
	logic [KEY_WIDTH-1:0]   key_q, key_d;
	logic [VALUE_WIDTH-1:0] value_q, value_d;
	logic                   place_q, place_d;
	logic [SizeW-1:0]       pos_q, pos_d, d_q, d_d, cnt_q, cnt_d, cnt_inc, pos_adv, d_adv;
	logic [SizeW:0]         s1, s2;
	logic [AW-1:0]          clr_q, clr_d, ra, wa;
	logic [CollW-1:0]       coll_q, coll_d;
	logic [SizeW-1:0]       occ_q, occ_d;
	logic                   done_q, done_d;
	status_t                status_q, status_d;
	logic [VALUE_WIDTH-1:0] fv_q, fv_d;
	logic [SizeW-1:0]       pc_q, pc_d;
	logic                   mark_we, kv_we;
	mark_t                  mark_wd;
	logic                   hit;

	assign ra = AW'(pos_q);
	assign wa = (state_q == B_CLEAR) ? clr_q : ra;

	always_ff @(posedge clk) begin
		if (mark_we) mark_mem[wa] <= mark_wd;
		if (kv_we) begin
			key_mem[wa] <= key_q;
			val_mem[wa] <= value_q;
		end
		mark_rd_q <= mark_mem[ra];
		key_rd_q  <= key_mem[ra];
		val_rd_q  <= val_mem[ra];
	end

	assign s1 = {1'b0, pos_q} + {1'b0, d_q};
	assign s2 = {1'b0, d_q} + {1'b0, job_q.inc};
	assign pos_adv = (s1 >= {1'b0, job_q.m}) ? SizeW'(s1 - {1'b0, job_q.m}) : SizeW'(s1);
	assign d_adv   = (s2 >= {1'b0, job_q.m}) ? SizeW'(s2 - {1'b0, job_q.m}) : SizeW'(s2);
	assign cnt_inc = cnt_q + 1'b1;
	assign hit     = (mark_rd_q == MARK_OCC) && (key_rd_q == key_q);

	always_comb begin
		state_d  = state_q;
		job_d    = job_q;
		key_d    = key_q;
		value_d  = value_q;
		place_d  = place_q;
		pos_d    = pos_q;
		d_d      = d_q;
		cnt_d    = cnt_q;
		clr_d    = clr_q;
		coll_d   = coll_q;
		occ_d    = occ_q;
		done_d   = 1'b0;
		status_d = status_q;
		fv_d     = fv_q;
		pc_d     = pc_q;
		mark_we  = 1'b0;
		kv_we    = 1'b0;
		mark_wd  = MARK_EMPTY;
		q_pop    = 1'b0;
		unique case (state_q)
			B_CLEAR: begin
				mark_we = 1'b1;
				clr_d   = clr_q + 1'b1;
				if (clr_q == AW'(TABLE_DEPTH - 1)) state_d = B_IDLE;
			end
			B_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					job_d   = q_job;
					key_d   = q_key;
					value_d = q_value;
					pos_d   = q_job.home;
					d_d     = q_job.d0;
					cnt_d   = '0;
					place_d = 1'b0;
					if (q_job.kind == KIND_OTHER) begin
						done_d   = 1'b1;
						status_d = ST_MISS;
						fv_d     = '0;
						pc_d     = '0;
					end else begin
						state_d = B_RD;
					end
				end
			end
			B_RD: state_d = B_EV;
			B_EV: begin
				fv_d = '0;
				pc_d = '0;
				state_d = B_RD;
				if (!place_q) begin
					if (hit) begin
						done_d  = 1'b1;
						state_d = B_IDLE;
						priority case (job_q.kind)
							KIND_SEARCH: begin
								status_d = ST_OK;
								fv_d     = val_rd_q;
								pc_d     = cnt_inc;
							end
							KIND_INSERT: status_d = ST_DUP;
							default: begin
								status_d = ST_OK;
								mark_we  = 1'b1;
								mark_wd  = MARK_DEL;
								if (occ_q != '0) occ_d = occ_q - 1'b1;
							end
						endcase
					end else if (mark_rd_q == MARK_EMPTY || cnt_inc == job_q.m) begin
						if (job_q.kind == KIND_INSERT) begin
							place_d = 1'b1;
							pos_d   = job_q.home;
							d_d     = job_q.d0;
							cnt_d   = '0;
						end else begin
							done_d   = 1'b1;
							state_d  = B_IDLE;
							status_d = ST_MISS;
							if (job_q.kind == KIND_SEARCH) pc_d = cnt_inc;
						end
					end else begin
						pos_d = pos_adv;
						d_d   = d_adv;
						cnt_d = cnt_inc;
					end
				end else begin
					if (mark_rd_q == MARK_OCC) begin
						if (coll_q != CollMax) coll_d = coll_q + 1'b1;
						if (cnt_inc == job_q.m) begin
							done_d   = 1'b1;
							state_d  = B_IDLE;
							status_d = ST_FULL;
						end else begin
							pos_d = pos_adv;
							d_d   = d_adv;
							cnt_d = cnt_inc;
						end
					end else begin
						mark_we  = 1'b1;
						mark_wd  = MARK_OCC;
						kv_we    = 1'b1;
						occ_d    = occ_q + 1'b1;
						done_d   = 1'b1;
						state_d  = B_IDLE;
						status_d = ST_OK;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_CLEAR;
			clr_q   <= '0;
			coll_q  <= '0;
			occ_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
			coll_q  <= coll_d;
			occ_q   <= occ_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		job_q    <= job_d;
		key_q    <= key_d;
		value_q  <= value_d;
		place_q  <= place_d;
		pos_q    <= pos_d;
		d_q      <= d_d;
		cnt_q    <= cnt_d;
		status_q <= status_d;
		fv_q     <= fv_d;
		pc_q     <= pc_d;
	end

	assign clearing        = (state_q == B_CLEAR);
	assign done            = done_q;
	assign status          = status_q;
	assign found_value     = fv_q;
	assign probe_count     = pc_q;
	assign collision_total = coll_q;
	assign item_count      = occ_q;

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == B_IDLE) else $error("result while probing");
	a_occ_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(occ_q) |-> done_q) else $error("item count moved without a result");
endmodule
`default_nettype wire

// ===== sv/open_addressing_hash_table_top.sv =====
// Top level of the open-addressing hash table.
//
// Items: raise start with kind, key, key_hash and value; the item is taken
// at a clock edge where start is high and busy is low. Kinds: search,
// insert, erase; any other kind gives a miss. One result per item, in
// order, shown for a single cycle with done high: status, found_value,
// probe_count, collision_total and item_count. The receiver cannot
// stall; results are never held. Configuration: cfg_we with cfg_index
// 0 (probe mode) or 1 (table size), to be written by the user only while
// the block is idle; the block itself does not enforce this.
// Flow: the front end reduces the hash one remainder bit per cycle, then
// reduces the probe increments, then queues the item (two entries),
// waiting while the queue is full; busy stays high throughout. The probe
// engine pops an item, then visits each slot as a registered memory read
// then an evaluate step; an insert that misses probes twice. The result
// appears the cycle after the deciding slot is evaluated. Front and back
// overlap across items.
// Reset: counters clear and the engine sweeps every slot mark to empty,
// with busy high; configuration is taken meanwhile.
`default_nettype none
module open_addressing_hash_table_top #(
	parameter int TABLE_DEPTH = 1024,
	parameter int KEY_WIDTH   = 64,
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic [1:0]                     kind,
	input  wire logic [KEY_WIDTH-1:0]           key,
	input  wire logic [oaht_pkg::HashW-1:0]     key_hash,
	input  wire logic [VALUE_WIDTH-1:0]         value,
	output logic                                done,
	output logic [1:0]                          status,
	output logic [VALUE_WIDTH-1:0]              found_value,
	output logic [oaht_pkg::SizeW-1:0]          probe_count,
	output logic [oaht_pkg::CollW-1:0]          collision_total,
	output logic [oaht_pkg::SizeW-1:0]          item_count,
	input  wire logic                           cfg_we,
	input  wire logic [oaht_pkg::CfgIdxW-1:0]   cfg_index,
	input  wire logic [oaht_pkg::CfgDataW-1:0]  cfg_data
);
	import oaht_pkg::*;

	logic             probe_mode_q;
	logic [SizeW-1:0] table_size_q;
	logic             take, front_busy, clearing, push, q_full, q_valid, q_pop;
	job_t             f_job, q_job;
	logic [KEY_WIDTH-1:0]   f_key, q_key;
	logic [VALUE_WIDTH-1:0] f_value, q_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_mode_q <= 1'b0;
			table_size_q <= SizeW'(MinSize);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PROBE_MODE: probe_mode_q <= cfg_data[0];
				CFG_TABLE_SIZE: table_size_q <= SizeW'(cfg_data);
			endcase
		end
	end

	assign busy = front_busy | clearing;
	assign take = start & ~busy;

	oaht_front #(
		.TABLE_DEPTH(TABLE_DEPTH), .KEY_WIDTH(KEY_WIDTH), .VALUE_WIDTH(VALUE_WIDTH)
	) u_front (
		.clk(clk), .arst_n(arst_n), .take(take), .kind(kind), .key(key),
		.key_hash(key_hash), .value(value), .probe_mode(probe_mode_q),
		.table_size(table_size_q), .q_full(q_full), .busy(front_busy),
		.push(push), .job(f_job), .push_key(f_key), .push_value(f_value)
	);

	oaht_fifo #(.KEY_WIDTH(KEY_WIDTH), .VALUE_WIDTH(VALUE_WIDTH)) u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .push_job(f_job),
		.push_key(f_key), .push_value(f_value), .pop(q_pop), .full(q_full),
		.valid(q_valid), .job(q_job), .key(q_key), .value(q_value)
	);

	oaht_back #(
		.TABLE_DEPTH(TABLE_DEPTH), .KEY_WIDTH(KEY_WIDTH), .VALUE_WIDTH(VALUE_WIDTH)
	) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_job(q_job),
		.q_key(q_key), .q_value(q_value), .q_pop(q_pop), .clearing(clearing),
		.done(done), .status(status), .found_value(found_value),
		.probe_count(probe_count), .collision_total(collision_total),
		.item_count(item_count)
	);

	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> busy) else $error("busy not raised after taking an item");
endmodule
`default_nettype wire
